// ===== design/atc_pkg.sv =====
`default_nettype none

package atc_pkg;

    localparam int WORD_W        = 32;
    localparam int MAT_DIM       = 4;
    localparam int MAT_SIZE      = MAT_DIM * MAT_DIM;
    localparam int IDX_W         = 4;
    localparam int FRAC_BITS_DEF = 16;

    // Packed stream widths
    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 1;

    typedef enum logic [1:0] {
        ACT_TRANSLATE = 2'd0,
        ACT_SCALE     = 2'd1,
        ACT_IDENTITY  = 2'd2,
        ACT_READ      = 2'd3
    } action_t;

    typedef struct packed {
        action_t                   action;
        logic signed [WORD_W-1:0]  offset_x;
        logic signed [WORD_W-1:0]  offset_y;
        logic signed [WORD_W-1:0]  scale_factor;
        logic [IDX_W-1:0]          element_index;
    } cmd_t;

    // New values of columns 0, 1 and 3 of one row, plus the clip flag
    typedef struct packed {
        logic signed [WORD_W-1:0] col0;
        logic signed [WORD_W-1:0] col1;
        logic signed [WORD_W-1:0] col3;
        logic                     clip;
    } row_upd_t;

endpackage

`default_nettype wire

// ===== design/atc_row.sv =====
`default_nettype none

module atc_row #(
    parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF
) (
    input  atc_pkg::action_t                       action,
    input  logic signed [atc_pkg::WORD_W-1:0]      col0,
    input  logic signed [atc_pkg::WORD_W-1:0]      col1,
    input  logic signed [atc_pkg::WORD_W-1:0]      col3,
    input  logic signed [atc_pkg::WORD_W-1:0]      offset_x,
    input  logic signed [atc_pkg::WORD_W-1:0]      offset_y,
    input  logic signed [atc_pkg::WORD_W-1:0]      scale_factor,
    output atc_pkg::row_upd_t                      upd
);

    localparam int W      = atc_pkg::WORD_W;
    localparam int PROD_W = 2 * W;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic signed [SUM_W-1:0] MAX_V = {{(SUM_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MIN_V = {{(SUM_W-W+1){1'b1}}, {(W-1){1'b0}}};

    logic signed [W-1:0]      mul_a;
    logic signed [W-1:0]      mul_b;
    logic signed [PROD_W-1:0] prod0;
    logic signed [PROD_W-1:0] prod1;
    logic signed [SUM_W-1:0]  q0;
    logic signed [SUM_W-1:0]  q1;
    logic signed [SUM_W-1:0]  sum3;
    logic [W:0]               sat0;
    logic [W:0]               sat1;
    logic [W:0]               sat3;

    // Clip to the word range; bit W flags a clip
    function automatic logic [W:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic [W:0] r;
        if (v > MAX_V)
            r = {1'b1, MAX_V[W-1:0]};
        else if (v < MIN_V)
            r = {1'b1, MIN_V[W-1:0]};
        else
            r = {1'b0, v[W-1:0]};
        return r;
    endfunction

    // One multiplier each for columns 0 and 1, shared between translate and scale
    assign mul_a = (action == atc_pkg::ACT_TRANSLATE) ? offset_x : scale_factor;
    assign mul_b = (action == atc_pkg::ACT_TRANSLATE) ? offset_y : scale_factor;

    assign prod0 = col0 * mul_a;
    assign prod1 = col1 * mul_b;

    // Arithmetic shift floors toward minus infinity
    assign q0   = SUM_W'(prod0 >>> FRAC_BITS);
    assign q1   = SUM_W'(prod1 >>> FRAC_BITS);
    assign sum3 = q0 + q1 + SUM_W'(col3);

    assign sat0 = sat_word(q0);
    assign sat1 = sat_word(q1);
    assign sat3 = sat_word(sum3);

    always_comb
    begin
        upd.col0 = col0;
        upd.col1 = col1;
        upd.col3 = col3;
        upd.clip = 1'b0;
        case (action)
            atc_pkg::ACT_TRANSLATE:
            begin
                upd.col3 = sat3[W-1:0];
                upd.clip = sat3[W];
            end
            atc_pkg::ACT_SCALE:
            begin
                upd.col0 = sat0[W-1:0];
                upd.col1 = sat1[W-1:0];
                upd.clip = sat0[W] | sat1[W];
            end
            default:
            begin
                upd.clip = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/affine_transform_composer.sv =====
// affine_transform_composer
//
// Holds one 4x4 row-major transform matrix in signed fixed point (FRAC_BITS
// fraction bits, Q16.16 by default) and composes translations and uniform xy
// scales onto it from the right. Commands arrive on the s_axis channel: the
// action code in tuser, the operands in tdata. Every command returns exactly
// one word on the m_axis channel: the requested element for a read (zero
// otherwise) in tdata and the clip flag in tuser.
//
// Flow: an accepted word sits in the input register; from there the eight
// row multipliers (two per row) evaluate it, and the matrix update and the
// result are registered together, which raises m_axis_tvalid. Throughput is
// one command per cycle while the receiver does not stall; each command sees
// the matrix as left by the one before it, since the update commits in the
// same cycle that the command leaves the input register.
//
// Reset loads the identity matrix and empties both registers. When the
// receiver stalls, the result is held in the output register and one more
// command may wait in the input register; s_axis_tready drops only when both
// are full and m_axis_tready is low.

`default_nettype none

module affine_transform_composer #(
    parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] offset_x, [63:32] offset_y, [95:64] scale_factor,
    // [99:96] element_index, [103:100] zero
    input  logic [atc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] action
    input  logic [atc_pkg::IN_USER_W-1:0]      s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] element_value
    output logic [atc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] saturated
    output logic [atc_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    localparam int W   = atc_pkg::WORD_W;
    localparam int DIM = atc_pkg::MAT_DIM;
    localparam int N   = atc_pkg::MAT_SIZE;

    localparam logic [W-1:0] ONE_Q = W'(64'd1 << FRAC_BITS);

    atc_pkg::cmd_t          cmd_reg;
    logic                   in_valid_reg;
    logic signed [W-1:0]    mat_reg [N];
    logic [W-1:0]           value_reg;
    logic                   sat_reg;
    logic                   out_valid_reg;

    logic                   advance;
    logic                   commit;
    logic                   accept;
    atc_pkg::row_upd_t      row_upd [DIM];
    logic [DIM-1:0]         row_clip;
    logic [W-1:0]           value_next;
    logic                   sat_next;

    // Output register frees when empty or when its word is taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign commit        = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Capture the command word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.action        <= atc_pkg::action_t'(s_axis_tuser[1:0]);
            cmd_reg.offset_x      <= s_axis_tdata[31:0];
            cmd_reg.offset_y      <= s_axis_tdata[63:32];
            cmd_reg.scale_factor  <= s_axis_tdata[95:64];
            cmd_reg.element_index <= s_axis_tdata[99:96];
        end
    end

    // One arithmetic unit per row
    for (genvar r = 0; r < DIM; r++)
    begin : g_row
        atc_row #(
            .FRAC_BITS    (FRAC_BITS)
        ) u_row (
            .action       (cmd_reg.action),
            .col0         (mat_reg[DIM*r]),
            .col1         (mat_reg[DIM*r+1]),
            .col3         (mat_reg[DIM*r+3]),
            .offset_x     (cmd_reg.offset_x),
            .offset_y     (cmd_reg.offset_y),
            .scale_factor (cmd_reg.scale_factor),
            .upd          (row_upd[r])
        );
        assign row_clip[r] = row_upd[r].clip;
    end

    // Read returns the element, the other actions return zero
    always_comb
    begin
        value_next = '0;
        sat_next   = 1'b0;
        case (cmd_reg.action)
            atc_pkg::ACT_TRANSLATE,
            atc_pkg::ACT_SCALE:
                sat_next = |row_clip;
            atc_pkg::ACT_READ:
                value_next = mat_reg[cmd_reg.element_index];
            default:
                sat_next = 1'b0;
        endcase
    end

    // Matrix update commits together with the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
                mat_reg[i] <= (i % (DIM + 1) == 0) ? ONE_Q : '0;
        end
        else if (commit)
        begin
            case (cmd_reg.action)
                atc_pkg::ACT_TRANSLATE,
                atc_pkg::ACT_SCALE:
                begin
                    for (int r = 0; r < DIM; r++)
                    begin
                        mat_reg[DIM*r]   <= row_upd[r].col0;
                        mat_reg[DIM*r+1] <= row_upd[r].col1;
                        mat_reg[DIM*r+3] <= row_upd[r].col3;
                    end
                end
                atc_pkg::ACT_IDENTITY:
                begin
                    for (int i = 0; i < N; i++)
                        mat_reg[i] <= (i % (DIM + 1) == 0) ? ONE_Q : '0;
                end
                default:
                begin
                    mat_reg[0] <= mat_reg[0];
                end
            endcase
        end
    end

    // Result register: load on commit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = value_reg;
    assign m_axis_tuser[0] = sat_reg;

    // A clipped step is never a read, so its value must be zero
    a_sat_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("saturated result carries a nonzero value");

    // Identity reload lands on the diagonal and off it
    a_identity_load: assert property (@(posedge clk) disable iff (!rst_n)
        commit && cmd_reg.action == atc_pkg::ACT_IDENTITY
        |=> mat_reg[0] == ONE_Q && mat_reg[5] == ONE_Q && mat_reg[1] == '0
            && mat_reg[3] == '0)
        else $error("identity reload left wrong elements");

    // A read leaves the matrix untouched (checked on elements 0, 1 and 3)
    a_read_keeps_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        commit && cmd_reg.action == atc_pkg::ACT_READ
        |=> $stable(mat_reg[0]) && $stable(mat_reg[1]) && $stable(mat_reg[3]))
        else $error("read changed the matrix");

    // A result word appears only after a command was committed
    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(commit))
        else $error("result word without a committed command");

endmodule

`default_nettype wire
